// File: src/rrab_pkg.sv
`default_nettype none
package rrab_pkg;
  localparam int FRAME_WIDTH_DEF  = 1024;
  localparam int FRAME_HEIGHT_DEF = 1024;
  localparam int STRIPE_WIDTH_DEF = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_H   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRIPE   = 3'd7;
  localparam int STRIPE_DARKEN  = 30;
  localparam int ALPHA_SKIP_MAX = 2;
  localparam int ALPHA_FULL_MIN = 253;
  // square-root operand D*65536 < 2^40, root < 2^20
  localparam int SQ_W    = 40;
  localparam int ROOT_W  = 20;
  localparam int NCELLS  = ROOT_W;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] a;
  } pix_t;

  // what travels alongside the square-root cells
  typedef struct packed {
    pix_t        pix;
    logic        active;   // inside and not skipped
    logic        use_root; // coverage from root
    logic        dark;
    logic [10:0] rad;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sq_t;
endpackage
`default_nettype wire

// File: src/rrab_if.sv
`default_nettype none
interface rrab_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/rrab_cell.sv
`default_nettype none
// One restoring square-root step: one root bit per cell.
module rrab_cell
  import rrab_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  vld_in,
  input  wire sq_t   sq_in,
  input  wire side_t side_in,
  output logic       vld_out,
  output sq_t        sq_out,
  output side_t      side_out
);
  localparam int SH = 2 * (ROOT_W - 1 - STEP);
  logic          vld_r;
  sq_t           sq_r, sq_nxt;
  side_t         side_r;
  logic [SQ_W:0] trial;

  always_comb begin
    // trial = (root*4+1) << SH, compared against remainder
    trial  = ({{(SQ_W-ROOT_W-1){1'b0}}, sq_in.root, 2'b01}) << SH;
    sq_nxt = sq_in;
    if ({1'b0, sq_in.rem} >= trial) begin
      sq_nxt.rem  = sq_in.rem - trial[SQ_W-1:0];
      sq_nxt.root = {sq_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      sq_nxt.root = {sq_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      sq_r   <= sq_nxt;
      side_r <= side_in;
    end
  end
  assign vld_out  = vld_r;
  assign sq_out   = sq_r;
  assign side_out = side_r;
endmodule
`default_nettype wire

// File: src/rounded_rect_aa_fill_blend.sv
// Rounded-rectangle fill blended over a pixel stream.
// Input channel in_ carries one frame pixel (x, y, BGRA); output channel
// out_ returns the blended pixel and a modified flag, one item per input.
// cfg_ is a plain write port (index per register list); the user must
// write it only while the block is idle, which the block does not enforce.
// Pipeline: one geometry stage, one stage for the squares and the stripe
// parity, one for the distance sum and band compare, a chain of 20
// square-root cells (one root bit each), one coverage/alpha stage, one
// multiply stage and the output register.
// Throughput: one item per clock; the chain advances as one piece, so the
// whole pipeline holds when out_ready is low and the output register is
// full, and in_ready follows that hold.
// Reset (synchronous, rst_n low) clears the configuration registers to
// zero and empties the pipeline.
`default_nettype none
module rounded_rect_aa_fill_blend
  import rrab_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int STRIPE_WIDTH = STRIPE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rrab_if.sink                       in_ch,
  rrab_if.source                     out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  // stripe index by reciprocal multiply, exact for sums below 2^13
  localparam int KQ_SH = 19;
  localparam logic [19:0] KQ_MUL =
    20'(((1 << KQ_SH) + STRIPE_WIDTH - 1) / STRIPE_WIDTH);

  logic signed [11:0] rx0_r, ry0_r;
  logic [11:0] rw_r, rh_r;
  logic [10:0] radx_r, rady_r;
  logic [31:0] fill_r;
  logic        stripe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx0_r <= '0; ry0_r <= '0; rw_r <= '0; rh_r <= '0;
      radx_r <= '0; rady_r <= '0; fill_r <= '0; stripe_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RECT_X: rx0_r    <= cfg_data[11:0];
        REG_RECT_Y: ry0_r    <= cfg_data[11:0];
        REG_RECT_W: rw_r     <= cfg_data[11:0];
        REG_RECT_H: rh_r     <= cfg_data[11:0];
        REG_RAD_X:  radx_r   <= cfg_data[10:0];
        REG_RAD_Y:  rady_r   <= cfg_data[10:0];
        REG_FILL:   fill_r   <= cfg_data;
        REG_STRIPE: stripe_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline enable: hold everything while the output is full and stalled
  logic out_vld_r, en;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  wire logic acc = in_ch.valid && en;

  pix_t pin;
  assign pin = pix_t'(in_ch.data);

  // ---- stage 1: geometry
  typedef logic signed [15:0] s16_t;
  s16_t px, py, x0, y0, x1, y1, rxs, rys, dx, dy, ox, oy;
  logic in_rect;
  logic [12:0] ksum;
  always_comb begin
    px = s16_t'({6'd0, pin.x});
    py = s16_t'({6'd0, pin.y});
    x0 = s16_t'(rx0_r); y0 = s16_t'(ry0_r);
    x1 = x0 + s16_t'({4'd0, rw_r});
    y1 = y0 + s16_t'({4'd0, rh_r});
    rxs = s16_t'({5'd0, radx_r});
    rys = s16_t'({5'd0, rady_r});
    in_rect = px >= x0 && px < x1 && py >= y0 && py < y1 &&
              px < s16_t'(FRAME_WIDTH) && py < s16_t'(FRAME_HEIGHT);
    if (px < x0 + rxs) dx = x0 + rxs - px;
    else if (px >= x1 - rxs) dx = px - (x1 - rxs) + 16'sd1;
    else dx = '0;
    if (py < y0 + rys) dy = y0 + rys - py;
    else if (py >= y1 - rys) dy = py - (y1 - rys) + 16'sd1;
    else dy = '0;
    ox = px - x0; oy = py - y0;
    ksum = 13'(ox + oy);  // non-negative when inside the rectangle
  end

  logic        s1_v_r, s1_in_r, s1_corner_r;
  logic [11:0] s1_dx_r, s1_dy_r;
  logic [12:0] s1_ksum_r;
  pix_t        s1_pix_r;
  logic [10:0] s1_rad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= acc;
    if (en) begin
      s1_pix_r    <= pin;
      s1_in_r     <= in_rect;
      s1_corner_r <= dx > 0 && dy > 0;
      s1_dx_r     <= dx[11:0];
      s1_dy_r     <= dy[11:0];
      s1_ksum_r   <= ksum;
      s1_rad_r    <= radx_r;
    end
  end

  // ---- stage 2: squares and stripe parity
  logic [32:0] kq;
  assign kq = {20'd0, s1_ksum_r} * {13'd0, KQ_MUL};
  side_t s2_side_nxt;
  always_comb begin
    s2_side_nxt.pix      = s1_pix_r;
    s2_side_nxt.active   = s1_in_r;
    s2_side_nxt.use_root = 1'b0;
    s2_side_nxt.dark     = stripe_r && !kq[KQ_SH];
    s2_side_nxt.rad      = s1_rad_r;
  end

  logic        s2_v_r;
  side_t       s2_side_r;
  logic        s2_corner_r;
  logic [23:0] s2_dx2_r, s2_dy2_r, s2_r2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
    if (en) begin
      s2_side_r   <= s2_side_nxt;
      s2_corner_r <= s1_corner_r;
      s2_dx2_r <= s1_dx_r * s1_dx_r;
      s2_dy2_r <= s1_dy_r * s1_dy_r;
      s2_r2_r  <= 24'(s1_rad_r) * 24'(s1_rad_r);
    end
  end

  // ---- stage 3: sum and band compare
  logic [24:0] d2;
  logic [23:0] r1;
  assign d2 = 25'(s2_dx2_r) + 25'(s2_dy2_r);
  assign r1 = s2_r2_r + 24'({s2_side_r.rad, 1'b0}) + 24'd1;
  side_t s3_side_nxt;
  always_comb begin
    s3_side_nxt = s2_side_r;
    // drop pixels beyond the one-pixel band
    if (s2_corner_r && d2 >= 25'(r1)) s3_side_nxt.active = 1'b0;
    s3_side_nxt.use_root = s2_corner_r && d2 > 25'(s2_r2_r);
  end

  logic  s3_v_r;
  side_t s3_side_r;
  sq_t   s3_sq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
    if (en) begin
      s3_side_r    <= s3_side_nxt;
      s3_sq_r.rem  <= {d2[23:0], 16'd0};
      s3_sq_r.root <= '0;
    end
  end

  // ---- square-root chain
  logic  cv [NCELLS+1];
  sq_t   cs [NCELLS+1];
  side_t cd [NCELLS+1];
  assign cv[0] = s3_v_r;
  assign cs[0] = s3_sq_r;
  assign cd[0] = s3_side_r;
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    rrab_cell #(.STEP(i)) u_cell (
      .clk, .rst_n, .en,
      .vld_in(cv[i]), .sq_in(cs[i]), .side_in(cd[i]),
      .vld_out(cv[i+1]), .sq_out(cs[i+1]), .side_out(cd[i+1])
    );
  end

  // ---- coverage and alpha
  side_t       tl;
  logic [20:0] diff;
  logic [8:0]  cov;
  logic [16:0] prod;
  logic [7:0]  sr, sg, sb;
  assign tl   = cd[NCELLS];
  assign diff = {1'b0, cs[NCELLS].root} - {2'b0, tl.rad, 8'd0};
  always_comb begin
    cov = 9'd256;
    if (tl.use_root) cov = 9'd256 - ((diff > 21'd255) ? 9'd255 : diff[8:0]);
    prod = cov * fill_r[7:0];
    sr = fill_r[31:24]; sg = fill_r[23:16]; sb = fill_r[15:8];
    if (tl.dark) begin
      sr = (sr >= 8'(STRIPE_DARKEN)) ? sr - 8'(STRIPE_DARKEN) : 8'd0;
      sg = (sg >= 8'(STRIPE_DARKEN)) ? sg - 8'(STRIPE_DARKEN) : 8'd0;
      sb = (sb >= 8'(STRIPE_DARKEN)) ? sb - 8'(STRIPE_DARKEN) : 8'd0;
    end
  end

  logic       a_v_r, a_act_r;
  pix_t       a_pix_r;
  logic [7:0] a8_r, a_sr_r, a_sg_r, a_sb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= cv[NCELLS];
    if (en) begin
      a_pix_r <= tl.pix; a_act_r <= tl.active;
      a8_r <= prod[15:8];
      a_sr_r <= sr; a_sg_r <= sg; a_sb_r <= sb;
    end
  end

  // ---- multiply stage
  logic [7:0]  inv;
  assign inv = 8'd255 - a8_r;
  logic        m_v_r, m_full_r, m_mix_r;
  pix_t        m_pix_r;
  logic [7:0]  m_a8_r, m_sr_r, m_sg_r, m_sb_r;
  logic [15:0] m_r_r, m_g_r, m_b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else if (en) m_v_r <= a_v_r;
    if (en) begin
      m_pix_r  <= a_pix_r;
      m_a8_r   <= a8_r;
      m_sr_r <= a_sr_r; m_sg_r <= a_sg_r; m_sb_r <= a_sb_r;
      m_full_r <= a_act_r && a8_r >= 8'(ALPHA_FULL_MIN);
      m_mix_r  <= a_act_r && a8_r > 8'(ALPHA_SKIP_MAX) && a8_r < 8'(ALPHA_FULL_MIN);
      m_r_r <= a_pix_r.r * inv + a_sr_r * a8_r;
      m_g_r <= a_pix_r.g * inv + a_sg_r * a8_r;
      m_b_r <= a_pix_r.b * inv + a_sb_r * a8_r;
    end
  end

  // ---- output register: b, g, r, a, modified
  logic [32:0] out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= m_v_r;
    if (en) begin
      if (m_full_r)
        out_r <= {m_sb_r, m_sg_r, m_sr_r, 8'd255, 1'b1};
      else if (m_mix_r)
        out_r <= {m_b_r[15:8], m_g_r[15:8], m_r_r[15:8],
                  (m_a8_r > m_pix_r.a) ? m_a8_r : m_pix_r.a, 1'b1};
      else
        out_r <= {m_pix_r.b, m_pix_r.g, m_pix_r.r, m_pix_r.a, 1'b0};
    end
  end
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;
endmodule
`default_nettype wire

// File: tb/tb_rounded_rect_aa_fill_blend.sv
`default_nettype none
module tb_rounded_rect_aa_fill_blend;
  import rrab_pkg::*;

  localparam int OUT_W = 33;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rrab_if #(.W($bits(pix_t))) in_if ();
  rrab_if #(.W(OUT_W)) out_if ();

  rounded_rect_aa_fill_blend dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block's registers
  longint rect_left, rect_top, rect_w, rect_h, rad_x, rad_y;
  logic [31:0] fill_rgba;
  logic stripes;

  pix_t pixel_queue[$];
  logic [OUT_W-1:0] expected_pixels[$];
  int fail_count = 0;
  int pixels_in = 0, pixels_out = 0, blended_count = 0;
  logic in_took = 1'b0, out_took = 1'b0;
  logic quiet = 1'b0;
  logic hold_sender = 1'b0;
  int long_hold = 0;
  int send_gap = 0, recv_gap = 0;

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 12));
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r + (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint corner_offset(longint p, longint lo, longint hi, longint r);
    if (p < lo + r) return lo + r - p;
    if (p >= hi - r) return p - (hi - r) + 1;
    return 0;
  endfunction

  function automatic int mix_channel(int d, int s, int a);
    return ((d * (255 - a) + s * a) >> 8) & 255;
  endfunction

  function automatic int darken(int c);
    return (c >= STRIPE_DARKEN) ? c - STRIPE_DARKEN : 0;
  endfunction

  function automatic logic [OUT_W-1:0] blend_pixel(pix_t p);
    longint px, py, x1, y1, dx, dy, d2, s, diff, k;
    int cov, a8, sr, sg, sb, fa, ob, og, orr, oa;
    logic m, skip;
    px = p.x; py = p.y;
    ob = p.b; og = p.g; orr = p.r; oa = p.a; m = 1'b0;
    x1 = rect_left + rect_w; y1 = rect_top + rect_h;
    if (px >= rect_left && px < x1 && py >= rect_top && py < y1) begin
      dx = corner_offset(px, rect_left, x1, rad_x);
      dy = corner_offset(py, rect_top, y1, rad_y);
      cov = 256; skip = 1'b0;
      if (dx > 0 && dy > 0) begin
        d2 = dx * dx + dy * dy;
        if (d2 >= (rad_x + 1) * (rad_x + 1)) skip = 1'b1;
        else if (d2 > rad_x * rad_x) begin
          s = root_floor(d2 << 16);
          diff = s - (rad_x << 8);
          if (diff > 255) diff = 255;
          cov = 256 - int'(diff);
        end
      end
      if (!skip) begin
        sr = fill_rgba[31:24]; sg = fill_rgba[23:16];
        sb = fill_rgba[15:8]; fa = fill_rgba[7:0];
        a8 = (cov * fa) >> 8;
        if (stripes) begin
          k = ((px - rect_left) + (py - rect_top)) / STRIPE_WIDTH_DEF;
          if (k[0] == 1'b0) begin
            sr = darken(sr); sg = darken(sg); sb = darken(sb);
          end
        end
        if (a8 >= ALPHA_FULL_MIN) begin
          ob = sb; og = sg; orr = sr; oa = 255; m = 1'b1;
        end else if (a8 > ALPHA_SKIP_MAX) begin
          ob = mix_channel(p.b, sb, a8);
          og = mix_channel(p.g, sg, a8);
          orr = mix_channel(p.r, sr, a8);
          oa = (a8 > p.a) ? a8 : p.a;
          m = 1'b1;
        end
      end
    end
    return {ob[7:0], og[7:0], orr[7:0], oa[7:0], m};
  endfunction

  task automatic note_mismatch(string field, int got, int want);
    $display("mismatch on %s at result %0d: got %0d, want %0d", field, pixels_out, got, want);
    fail_count++;
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end else if (in_if.valid && !in_took) begin
      // hold the item until it is taken
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_if.valid <= 1'b0;
    end else if (pixel_queue.size() > 0 && !hold_sender) begin
      in_if.data <= pixel_queue.pop_front();
      in_if.valid <= 1'b1;
      send_gap <= draw_gap();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    int gap;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_if.ready <= 1'b0;
    end else if (out_took) begin
      gap = draw_gap();
      recv_gap <= (gap > 0) ? gap - 1 : 0;
      out_if.ready <= (gap == 0);
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    in_took <= rst_n && in_if.valid && in_if.ready;
    out_took <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      expected_pixels.push_back(blend_pixel(pix_t'(in_if.data)));
      pixels_in++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("unexpected item", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_if.data[32:25] != want[32:25]) note_mismatch("blue", out_if.data[32:25], want[32:25]);
        if (out_if.data[24:17] != want[24:17]) note_mismatch("green", out_if.data[24:17], want[24:17]);
        if (out_if.data[16:9] != want[16:9]) note_mismatch("red", out_if.data[16:9], want[16:9]);
        if (out_if.data[8:1] != want[8:1]) note_mismatch("alpha", out_if.data[8:1], want[8:1]);
        if (out_if.data[0] != want[0]) note_mismatch("modified", out_if.data[0], want[0]);
        if (want[0]) blended_count++;
      end
      pixels_out++;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[31:0];
    case (idx)
      REG_RECT_X: rect_left = longint'($signed(value[11:0]));
      REG_RECT_Y: rect_top = longint'($signed(value[11:0]));
      REG_RECT_W: rect_w = value[11:0];
      REG_RECT_H: rect_h = value[11:0];
      REG_RAD_X: rad_x = value[10:0];
      REG_RAD_Y: rad_y = value[10:0];
      REG_FILL: fill_rgba = value[31:0];
      REG_STRIPE: stripes = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_rect(longint x, longint y, longint w, longint h, longint rx,
                          longint ry, longint fill, longint stripe);
    write_reg(REG_RECT_X, x);
    write_reg(REG_RECT_Y, y);
    write_reg(REG_RECT_W, w);
    write_reg(REG_RECT_H, h);
    write_reg(REG_RAD_X, rx);
    write_reg(REG_RAD_Y, ry);
    write_reg(REG_FILL, fill);
    write_reg(REG_STRIPE, stripe);
  endtask

  task automatic drain();
    while (pixel_queue.size() > 0 || in_if.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic queue_at(int x, int y);
    pix_t p;
    p.x = x[9:0]; p.y = y[9:0];
    p.b = 8'($urandom); p.g = 8'($urandom); p.r = 8'($urandom); p.a = 8'($urandom);
    pixel_queue.push_back(p);
  endtask

  // mostly pixels around the rectangle, the rest anywhere in the frame
  task automatic queue_random(int n);
    int x, y;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7 && rect_w < 1100 && rect_h < 1100) begin
        x = int'(rect_left) + int'($urandom_range(0, int'(rect_w) + 7)) - 4;
        y = int'(rect_top) + int'($urandom_range(0, int'(rect_h) + 7)) - 4;
        if (x < 0) x = 0;
        if (x > 1023) x = 1023;
        if (y < 0) y = 0;
        if (y > 1023) y = 1023;
      end else begin
        x = $urandom_range(0, 1023);
        y = $urandom_range(0, 1023);
      end
      queue_at(x, y);
    end
  endtask

  int settings_run = 0;

  initial begin
    rect_left = 0; rect_top = 0; rect_w = 0; rect_h = 0; rad_x = 0; rad_y = 0;
    fill_rgba = '0; stripes = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: empty rectangle, everything passes through
    queue_at(0, 0);
    queue_at(1023, 1023);
    queue_at(512, 300);
    drain();

    set_rect(100, 50, 200, 120, 20, 16, 64'hC8643280, 0);
    queue_at(100, 50);   // corner tip, beyond the band
    queue_at(110, 60);
    queue_at(106, 57);
    queue_at(105, 58);
    queue_at(200, 100);  // plain interior
    queue_at(299, 169);
    queue_at(99, 50);    // just outside
    queue_at(300, 50);
    queue_at(200, 170);
    queue_at(119, 65);
    queue_at(1023, 1023);
    queue_at(0, 0);
    drain();

    // full replace with stripes, channels below the darken step
    write_reg(REG_FILL, 64'h10F01EFF);
    write_reg(REG_STRIPE, 1);
    for (int i = 0; i < 8; i++) queue_at(150 + i, 100);
    drain();

    // alpha at the skip threshold
    write_reg(REG_FILL, 64'hFFFFFF02);
    queue_at(200, 100);
    queue_at(101, 70);
    drain();
    settings_run = 4;

    for (int s = 0; s < 14; s++) begin
      case (s)
        0: set_rect(-2048, -2048, 2048, 2048, 1024, 1024, 64'hFFFFFFFF, 1);
        1: set_rect(0, 0, 2048, 2048, 1024, 1024, 64'h00000080, 0);
        2: set_rect(2047, 2047, 2048, 2048, 0, 0, 64'hFFFFFFFF, 0);
        3: set_rect(10, 20, 4095, 4095, 2047, 2047, 64'h123456C0, 1);
        4: set_rect(-3, -2, 40, 30, 12, 9, 64'hFF00FFFE, 1);
        default: set_rect(int'($urandom_range(0, 1100)) - 50,
                          int'($urandom_range(0, 1100)) - 50,
                          $urandom_range(0, 300), $urandom_range(0, 300),
                          $urandom_range(0, 60), $urandom_range(0, 60),
                          {$urandom_range(0, 32'hFFFFFF), 8'($urandom_range(0, 255))},
                          $urandom_range(0, 1));
      endcase
      quiet = (s % 4 == 1);
      if (s == 6) begin
        // stall the receiver long enough for the pipeline to back up
        long_hold = 300;
        quiet = 1'b1;
      end
      if (s == 8) begin
        // pause the sender midway until every result is back
        queue_random(50);
        while (pixel_queue.size() > 25) @(posedge clk);
        hold_sender = 1'b1;
        while (in_if.valid || expected_pixels.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      queue_random(95);
      drain();
      settings_run++;
    end

    $display("covered %0d pixels over %0d register settings, %0d of them blended",
             pixels_out, settings_run, blended_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("timeout with %0d results outstanding", expected_pixels.size());
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
